/* hw/rtl/lcasr_pkg.sv */
// Shared types, constants and helpers for the load-cell ADC serial reader.
// Used by lcasr_ctrl, lcasr_dp, the top level and the checker.
`timescale 1ns / 1ps

package lcasr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int MAX_AVERAGE = 256;

    localparam int CNT_W    = $clog2(MAX_AVERAGE + 1);
    localparam int SUM_W    = SAMPLE_BITS + CNT_W;
    localparam int MAG_W    = SUM_W - 1;
    localparam int MEAN_W   = SAMPLE_BITS + 1;
    localparam int DIVC_W   = $clog2(MAG_W + 1);
    localparam int PULSE_W  = $clog2(SAMPLE_BITS + 4);
    localparam int HP_W     = 8;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = SAMPLE_BITS;
    localparam int CIDX_W   = 3;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_BITS    = 1 + SAMPLE_BITS + MEAN_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CIDX_W-1:0] REG_HALF_PERIOD = 3'd1;
    localparam logic [CIDX_W-1:0] REG_AVG_COUNT   = 3'd2;
    localparam logic [CIDX_W-1:0] REG_OFS_A_HIGH  = 3'd3;
    localparam logic [CIDX_W-1:0] REG_OFS_A_LOW   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_OFS_B       = 3'd5;

    // conversion modes
    localparam logic [MODE_W-1:0] MODE_A128 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_B32  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_A64  = 2'd2;

    // serial phases
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    typedef struct packed {
        logic tick_en;
        logic div_en;
        logic mean_load;
    } lcasr_cmd_t;

    typedef struct packed {
        logic mean_due;
        logic div_done;
    } lcasr_sts_t;

    function automatic logic [MODE_W-1:0] eff_mode(input logic [MODE_W-1:0] m);
        eff_mode = (m > MODE_A64) ? MODE_A64 : m;
    endfunction

endpackage

/* hw/rtl/lcasr_ctrl.sv */
// Controller: stream handshakes and the run/divide sequencing.
// Depends on lcasr_pkg; drives lcasr_dp through command and status structs.
`timescale 1ns / 1ps

module lcasr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  lcasr_pkg::lcasr_sts_t  sts,
    output lcasr_pkg::lcasr_cmd_t  cmd
);
    import lcasr_pkg::*;

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic state_reg, state_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_RUN) && out_free;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.tick_en   = s_tvalid && s_tready;
        cmd.div_en    = (state_reg == ST_DIV) && !sts.div_done;
        cmd.mean_load = (state_reg == ST_DIV) && sts.div_done;

        state_next = state_reg;
        unique case (state_reg)
            ST_RUN: begin
                if (cmd.tick_en && sts.mean_due) begin
                    state_next = ST_DIV;
                end
            end
            default: begin
                if (cmd.mean_load) begin
                    state_next = ST_RUN;
                end
            end
        endcase

        priority if ((cmd.tick_en && !sts.mean_due) || cmd.mean_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

/* hw/rtl/lcasr_dp.sv */
// Datapath: config registers, serial clock/shift logic, sample accumulator,
// restoring divider for the mean and the result registers. Depends on lcasr_pkg.
`timescale 1ns / 1ps

module lcasr_dp (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [lcasr_pkg::CIDX_W-1:0]            cfg_index,
    input  logic [lcasr_pkg::CFG_W-1:0]             cfg_wr_data,
    input  logic                                    data_level,
    input  lcasr_pkg::lcasr_cmd_t                   cmd,
    output lcasr_pkg::lcasr_sts_t                   sts,
    output logic                                    clock_level,
    output logic                                    sample_valid,
    output logic [lcasr_pkg::SAMPLE_BITS-1:0]       raw_sample,
    output logic                                    mean_valid,
    output logic [lcasr_pkg::MEAN_W-1:0]            mean_value
);
    import lcasr_pkg::*;

    // configuration
    logic [MODE_W-1:0]      mode_reg;
    logic [HP_W-1:0]        half_period_reg;
    logic [CNT_W-1:0]       avg_count_reg;
    logic [SAMPLE_BITS-1:0] ofs_a_high_reg;
    logic [SAMPLE_BITS-1:0] ofs_a_low_reg;
    logic [SAMPLE_BITS-1:0] ofs_b_reg;

    // serial state
    logic [1:0]             phase_reg, phase_next;
    logic [HP_W-1:0]        tick_count_reg, tick_count_next;
    logic [PULSE_W-1:0]     pulse_count_reg, pulse_count_next;
    logic [SAMPLE_BITS-1:0] shift_bits_reg, shift_bits_next;
    logic [MODE_W-1:0]      conv_mode_reg, conv_mode_next;
    logic [SUM_W-1:0]       sample_sum_reg;
    logic [CNT_W-1:0]       sample_count_reg;

    // divider
    logic [MAG_W-1:0]       quo_reg;
    logic [CNT_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       dvs_reg;
    logic                   neg_reg;
    logic [SAMPLE_BITS-1:0] off_reg;
    logic [DIVC_W-1:0]      div_cnt_reg;

    // result registers
    logic                   out_clk_reg;
    logic                   out_sv_reg;
    logic [SAMPLE_BITS-1:0] out_raw_reg;
    logic                   out_mv_reg;
    logic [MEAN_W-1:0]      out_mean_reg;

    logic [HP_W-1:0]        hp;
    logic [HP_W-1:0]        tick_inc;
    logic [PULSE_W-1:0]     pulse_inc;
    logic [PULSE_W-1:0]     pulse_limit;
    logic                   clk_lvl;
    logic                   sample_emit;
    logic [SUM_W-1:0]       sum_add;
    logic [CNT_W-1:0]       count_inc;
    logic [CNT_W-1:0]       cnt_eff;
    logic [MAG_W-1:0]       sum_mag;
    logic [SUM_W-1:0]       sum_neg;
    logic [MODE_W-1:0]      done_mode;
    logic [SAMPLE_BITS-1:0] off_sel;
    logic [CNT_W:0]         rem_sh;
    logic [CNT_W:0]         rem_sub;
    logic                   rem_ge;
    logic [MEAN_W-1:0]      quo_tr;
    logic [MEAN_W-1:0]      quo_s;
    logic [MEAN_W-1:0]      mean_calc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_A128;
            half_period_reg <= HP_W'(4);
            avg_count_reg   <= CNT_W'(160);
            ofs_a_high_reg  <= '0;
            ofs_a_low_reg   <= '0;
            ofs_b_reg       <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MODE:        mode_reg        <= cfg_wr_data[MODE_W-1:0];
                REG_HALF_PERIOD: half_period_reg <= cfg_wr_data[HP_W-1:0];
                REG_AVG_COUNT:   avg_count_reg   <= cfg_wr_data[CNT_W-1:0];
                REG_OFS_A_HIGH:  ofs_a_high_reg  <= cfg_wr_data[SAMPLE_BITS-1:0];
                REG_OFS_A_LOW:   ofs_a_low_reg   <= cfg_wr_data[SAMPLE_BITS-1:0];
                REG_OFS_B:       ofs_b_reg       <= cfg_wr_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        hp        = (half_period_reg == '0) ? HP_W'(1) : half_period_reg;
        tick_inc  = tick_count_reg + HP_W'(1);
        pulse_inc = pulse_count_reg + PULSE_W'(1);

        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        pulse_count_next = pulse_count_reg;
        shift_bits_next  = shift_bits_reg;
        conv_mode_next   = conv_mode_reg;
        clk_lvl          = 1'b0;
        sample_emit      = 1'b0;
        pulse_limit      = '0;

        unique case (phase_reg)
            PH_WAIT: begin
                if (!data_level) begin
                    phase_next       = PH_HIGH;
                    tick_count_next  = '0;
                    pulse_count_next = '0;
                    shift_bits_next  = '0;
                end
            end
            PH_HIGH: begin
                clk_lvl = 1'b1;
                if (tick_inc >= hp) begin
                    tick_count_next = '0;
                    phase_next      = PH_LOW;
                end else begin
                    tick_count_next = tick_inc;
                end
            end
            default: begin
                if (tick_inc >= hp) begin
                    tick_count_next  = '0;
                    pulse_count_next = pulse_inc;
                    if (pulse_count_reg < PULSE_W'(SAMPLE_BITS)) begin
                        shift_bits_next = {shift_bits_reg[SAMPLE_BITS-2:0], data_level};
                        if (pulse_inc == PULSE_W'(SAMPLE_BITS)) begin
                            sample_emit    = 1'b1;
                            conv_mode_next = eff_mode(mode_reg);
                        end
                    end
                    pulse_limit = PULSE_W'(SAMPLE_BITS) + PULSE_W'(conv_mode_next)
                                + PULSE_W'(1);
                    phase_next  = (pulse_count_next >= pulse_limit) ? PH_WAIT : PH_HIGH;
                end else begin
                    tick_count_next = tick_inc;
                end
            end
        endcase
    end

    always_comb begin
        sum_add   = sample_sum_reg
                  + {{(SUM_W-SAMPLE_BITS){shift_bits_next[SAMPLE_BITS-1]}}, shift_bits_next};
        count_inc = sample_count_reg + CNT_W'(1);
        priority if (avg_count_reg == '0) begin
            cnt_eff = CNT_W'(1);
        end else if (avg_count_reg > CNT_W'(MAX_AVERAGE)) begin
            cnt_eff = CNT_W'(MAX_AVERAGE);
        end else begin
            cnt_eff = avg_count_reg;
        end
        sts.mean_due = sample_emit && (count_inc >= cnt_eff);

        sum_neg = -sum_add;
        sum_mag = sum_add[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_add[MAG_W-1:0];

        done_mode = eff_mode(conv_mode_reg);
        unique case (done_mode)
            MODE_A128: off_sel = ofs_a_high_reg;
            MODE_B32:  off_sel = ofs_b_reg;
            default:   off_sel = ofs_a_low_reg;
        endcase

        rem_sh  = {rem_reg, quo_reg[MAG_W-1]};
        rem_ge  = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        sts.div_done = (div_cnt_reg == '0);

        quo_tr    = quo_reg[MEAN_W-1:0];
        quo_s     = neg_reg ? -quo_tr : quo_tr;
        mean_calc = quo_s - {{(MEAN_W-SAMPLE_BITS){off_reg[SAMPLE_BITS-1]}}, off_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_WAIT;
            tick_count_reg   <= '0;
            pulse_count_reg  <= '0;
            shift_bits_reg   <= '0;
            conv_mode_reg    <= MODE_A128;
            sample_sum_reg   <= '0;
            sample_count_reg <= '0;
            div_cnt_reg      <= '0;
        end else begin
            if (cmd.tick_en) begin
                phase_reg       <= phase_next;
                tick_count_reg  <= tick_count_next;
                pulse_count_reg <= pulse_count_next;
                shift_bits_reg  <= shift_bits_next;
                conv_mode_reg   <= conv_mode_next;
                if (sample_emit) begin
                    if (sts.mean_due) begin
                        sample_sum_reg   <= '0;
                        sample_count_reg <= '0;
                        div_cnt_reg      <= DIVC_W'(MAG_W);
                    end else begin
                        sample_sum_reg   <= sum_add;
                        sample_count_reg <= count_inc;
                    end
                end
            end else if (cmd.div_en) begin
                div_cnt_reg <= div_cnt_reg - DIVC_W'(1);
            end
        end
    end

    // divider operands and steps
    always_ff @(posedge aclk) begin
        if (cmd.tick_en && sts.mean_due) begin
            quo_reg <= sum_mag;
            rem_reg <= '0;
            dvs_reg <= count_inc;
            neg_reg <= sum_add[SUM_W-1];
            off_reg <= off_sel;
        end else if (cmd.div_en) begin
            quo_reg <= {quo_reg[MAG_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_en) begin
            out_clk_reg  <= clk_lvl;
            out_sv_reg   <= sample_emit;
            out_raw_reg  <= sample_emit ? shift_bits_next : '0;
            out_mv_reg   <= 1'b0;
            out_mean_reg <= '0;
        end else if (cmd.mean_load) begin
            out_mv_reg   <= 1'b1;
            out_mean_reg <= mean_calc;
        end
    end

    assign clock_level  = out_clk_reg;
    assign sample_valid = out_sv_reg;
    assign raw_sample   = out_raw_reg;
    assign mean_valid   = out_mv_reg;
    assign mean_value   = out_mean_reg;

endmodule

/* hw/rtl/load_cell_adc_serial_reader.sv */
// Top level of the load-cell ADC serial reader.
// Instantiates lcasr_ctrl and lcasr_dp; depends on lcasr_pkg.
//
// Usage: each input beat on s_ is one tick carrying the sampled level of the
// converter data pin (s_tdata bit 0). Each input beat produces exactly one
// output beat on m_ carrying the serial clock level to drive for that tick,
// plus the raw 24-bit sample on the tick a conversion completes and the
// offset-corrected mean on the tick a group of samples completes.
// Config writes (cfg_wr_en, cfg_index, cfg_wr_data) take effect at the clock
// edge; write only while no beat is outstanding.
// Latency: for ordinary ticks the output beat is registered and offered in the cycle
// after the input beat is taken. A tick that completes a mean first runs
// sum / count through the one-bit-per-cycle restoring divider, then loads the result.
// Throughput: one tick per cycle, apart from the divider stall on mean ticks and output back-pressure.
// The output register decouples the sides: a new beat is taken in the cycle
// the held result is consumed. If m_tready stays low, s_tready drops and the
// serial state holds.
// Reset (aresetn low, synchronous) restores register defaults, returns to
// waiting for data low and clears the accumulator; no reset sweep is needed.
`timescale 1ns / 1ps

module load_cell_adc_serial_reader (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lcasr_pkg::CIDX_W-1:0]        cfg_index,
    input  logic [lcasr_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcasr_pkg::IN_TDATA_W-1:0]    s_tdata,   // [0] data_level
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] clock_level, [24:1] raw_sample, [49:25] mean_value, rest zero
    output logic [lcasr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [lcasr_pkg::OUT_TUSER_W-1:0]   m_tuser    // [0] sample_valid, [1] mean_valid
);
    import lcasr_pkg::*;

    lcasr_cmd_t             cmd;
    lcasr_sts_t             sts;
    logic                   clock_level;
    logic                   sample_valid;
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic                   mean_valid;
    logic [MEAN_W-1:0]      mean_value;

    lcasr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lcasr_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .data_level   (s_tdata[0]),
        .cmd          (cmd),
        .sts          (sts),
        .clock_level  (clock_level),
        .sample_valid (sample_valid),
        .raw_sample   (raw_sample),
        .mean_valid   (mean_valid),
        .mean_value   (mean_value)
    );

    assign m_tdata = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, mean_value, raw_sample, clock_level};
    assign m_tuser = {mean_valid, sample_valid};

endmodule

/* hw/rtl/lcasr_checker.sv */
// Port-level checker for load_cell_adc_serial_reader, attached by bind.
// Depends on lcasr_pkg.
`timescale 1ns / 1ps

module lcasr_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lcasr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic [lcasr_pkg::OUT_TUSER_W-1:0]   m_tuser
);
    import lcasr_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // a mean only completes together with a sample
    a_mean_with_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("mean without sample");

    // raw field is zero unless a sample completed
    a_raw_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[SAMPLE_BITS:1] == '0)
        else $error("raw sample nonzero without sample flag");

    // samples are taken with the serial clock low
    a_clk_low_on_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> !m_tdata[0])
        else $error("sample completed with clock high");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind load_cell_adc_serial_reader lcasr_checker u_lcasr_checker (.*);

/* test/tb_top.sv */
// Testbench for load_cell_adc_serial_reader: drives pin-level ticks, predicts every
// output beat with its own serial/averaging model and checks it field by field.
// Depends on lcasr_pkg and the RTL of the reader; stands alone otherwise.
`timescale 1ns / 1ps

module tb_top;
    import lcasr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 48;
    localparam int RANDOM_TICKS   = 250;
    localparam int HOLD_CYCLES    = 250;
    localparam int MAX_PRINTS     = 40;

    // mode value outside the defined set; the block treats it as channel A gain 64
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    typedef struct {
        logic        clk_lvl;
        logic        smp_vld;
        logic [23:0] raw;
        logic        mean_vld;
        logic [24:0] mean;
    } reader_out_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CIDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]        cfg_wr_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata = '0;      // [0] data_level
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;           // [0] clock_level, [24:1] raw, [49:25] mean
    logic [OUT_TUSER_W-1:0]  m_tuser;           // [0] sample_valid, [1] mean_valid

    // register copies
    logic [MODE_W-1:0]       r_mode;
    logic [HP_W-1:0]         r_half;
    logic [8:0]              r_avg;
    logic signed [23:0]      r_ofs_ah;
    logic signed [23:0]      r_ofs_al;
    logic signed [23:0]      r_ofs_b;

    // serial and averaging state
    logic [1:0]              st_phase;
    logic [7:0]              st_ticks;
    logic [4:0]              st_pulses;
    logic [23:0]             st_shift;
    logic [MODE_W-1:0]       st_conv_mode;
    logic signed [32:0]      st_sum;
    logic [8:0]              st_count;

    logic                    tick_q[$];
    reader_out_t             expect_q[$];

    int  ticks_queued = 0;
    int  ticks_accepted = 0;
    int  out_beats = 0;
    int  samples_seen = 0;
    int  means_seen = 0;
    int  errors = 0;
    int  settings_used = 1;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  rx_cycles = 0;
    int  stuck = 0;
    bit  hold_done = 1'b0;
    bit  quiet = 1'b0;

    always #5 aclk = ~aclk;

    load_cell_adc_serial_reader u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    function automatic logic [MODE_W-1:0] clamp_mode(input logic [MODE_W-1:0] md);
        return (md > MODE_A64) ? MODE_A64 : md;
    endfunction

    function void reset_reader_model();
        r_mode = MODE_A128;
        r_half = 8'd4;
        r_avg = 9'd160;
        r_ofs_ah = '0;
        r_ofs_al = '0;
        r_ofs_b = '0;
        st_phase = PH_WAIT;
        st_ticks = '0;
        st_pulses = '0;
        st_shift = '0;
        st_conv_mode = MODE_A128;
        st_sum = '0;
        st_count = '0;
    endfunction

    // one tick of the pin interface; returns the beat it must produce
    function reader_out_t step_reader(input logic din);
        reader_out_t        r;
        logic [7:0]         hp;
        logic [8:0]         cnt;
        logic [MODE_W-1:0]  done_mode;
        logic signed [23:0] smp;
        logic signed [23:0] ofs;
        longint             quot;
        r = '{default: '0};
        hp = (r_half == 0) ? 8'd1 : r_half;
        case (st_phase)
            PH_WAIT: begin
                if (!din) begin
                    st_phase = PH_HIGH;
                    st_ticks = '0;
                    st_pulses = '0;
                    st_shift = '0;
                end
            end
            PH_HIGH: begin
                r.clk_lvl = 1'b1;
                st_ticks++;
                if (st_ticks >= hp) begin
                    st_ticks = '0;
                    st_phase = PH_LOW;
                end
            end
            default: begin
                st_ticks++;
                if (st_ticks >= hp) begin
                    st_ticks = '0;
                    if (st_pulses < SAMPLE_BITS) begin
                        st_shift = {st_shift[22:0], din};
                        st_pulses++;
                        if (st_pulses == SAMPLE_BITS) begin
                            smp = st_shift;
                            done_mode = clamp_mode(st_conv_mode);
                            r.smp_vld = 1'b1;
                            r.raw = st_shift;
                            st_sum = st_sum + smp;
                            st_count++;
                            cnt = (r_avg == 0) ? 9'd1 :
                                  (r_avg > MAX_AVERAGE) ? 9'(MAX_AVERAGE) : r_avg;
                            if (st_count >= cnt) begin
                                quot = longint'(st_sum) / longint'(st_count);
                                ofs = (done_mode == MODE_A128) ? r_ofs_ah :
                                      (done_mode == MODE_B32) ? r_ofs_b : r_ofs_al;
                                r.mean_vld = 1'b1;
                                r.mean = 25'(quot - longint'(ofs));
                                st_sum = '0;
                                st_count = '0;
                            end
                            st_conv_mode = clamp_mode(r_mode);
                        end
                    end else begin
                        st_pulses++;
                    end
                    if (st_pulses >= SAMPLE_BITS + clamp_mode(st_conv_mode) + 1)
                        st_phase = PH_WAIT;
                    else
                        st_phase = PH_HIGH;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH beat %0d %s: expected %0h got %0h", out_beats, what, want, got);
    endtask

    task automatic check_beat();
        reader_out_t e;
        out_beats++;
        if (expect_q.size() == 0) begin
            report_mismatch("beat with nothing pending", 0, m_tdata[31:0]);
        end else begin
            e = expect_q.pop_front();
            if (e.smp_vld) samples_seen++;
            if (e.mean_vld) means_seen++;
            if (m_tdata[0] !== e.clk_lvl)
                report_mismatch("clock_level", 32'(e.clk_lvl), 32'(m_tdata[0]));
            if (m_tdata[24:1] !== e.raw)
                report_mismatch("raw_sample", 32'(e.raw), 32'(m_tdata[24:1]));
            if (m_tdata[49:25] !== e.mean)
                report_mismatch("mean_value", 32'(e.mean), 32'(m_tdata[49:25]));
            if (m_tdata[OUT_TDATA_W-1:50] !== '0)
                report_mismatch("tdata padding", 0, 32'(m_tdata[OUT_TDATA_W-1:50]));
            if (m_tuser[0] !== e.smp_vld)
                report_mismatch("sample_valid", 32'(e.smp_vld), 32'(m_tuser[0]));
            if (m_tuser[1] !== e.mean_vld)
                report_mismatch("mean_valid", 32'(e.mean_vld), 32'(m_tuser[1]));
        end
    endtask

    // sender: holds tvalid until the beat is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 15) == 0) begin
                gap_left = $urandom_range(0, 7);
                s_tvalid <= 1'b0;
            end else if (tick_q.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= IN_TDATA_W'(tick_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off while beats are offered
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycles++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && rx_cycles > 300 && s_tvalid) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_beat();
            if (s_tvalid && s_tready) begin
                expect_q.push_back(step_reader(s_tdata[0]));
                ticks_accepted++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck = 0;
        end else begin
            stuck++;
            if (stuck >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no beat moved for %0d cycles", stuck);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // consecutive writes keep cfg_wr_en high; end_writes drops it
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_MODE:        r_mode = val[MODE_W-1:0];
            REG_HALF_PERIOD: r_half = val[HP_W-1:0];
            REG_AVG_COUNT:   r_avg = val[8:0];
            REG_OFS_A_HIGH:  r_ofs_ah = val;
            REG_OFS_A_LOW:   r_ofs_al = val;
            REG_OFS_B:       r_ofs_b = val;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic push_tick(input logic d);
        tick_q.push_back(d);
        ticks_queued++;
    endtask

    // one full read shaped to the current clock and mode settings; don't-care ticks random
    task automatic push_conversion(input logic [23:0] bits, input int gap);
        int hp;
        int extra;
        hp = (r_half == 0) ? 1 : r_half;
        extra = clamp_mode(r_mode) + 1;
        repeat (gap) push_tick(1'b1);
        push_tick(1'b0);
        for (int p = 23; p >= 0; p--) begin
            repeat (hp) push_tick(1'($urandom_range(0, 1)));
            repeat (hp - 1) push_tick(1'($urandom_range(0, 1)));
            push_tick(bits[p]);
        end
        repeat (2 * hp * extra) push_tick(1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        while (!(tick_q.size() == 0 && ticks_accepted == ticks_queued && expect_q.size() == 0))
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'h800000;
            1: return 24'h7fffff;
            2: return 24'h000000;
            3: return 24'hffffff;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_offset();
        case ($urandom_range(0, 6))
            0: return 24'h800000;
            1: return 24'h7fffff;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        int rand_ticks;
        int start;
        int sel;
        int val;
        rand_ticks = 0;
        reset_reader_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // register defaults after reset
        push_conversion(24'ha5c30f, 3);
        wait_idle();

        // zero half period, single-sample means, full-scale samples
        write_reg(REG_HALF_PERIOD, '0);
        write_reg(REG_AVG_COUNT, 24'd1);
        write_reg(REG_MODE, CFG_W'(MODE_A128));
        write_reg(REG_OFS_A_HIGH, 24'h800000);
        end_writes();
        push_conversion(24'h7fffff, 1);
        push_conversion(24'h800000, 4);
        push_conversion(24'h000000, 1);
        push_conversion(24'hffffff, 2);
        wait_idle();

        // reserved mode, zero count, offsets at the extremes
        write_reg(REG_MODE, CFG_W'(MODE_RESERVED));
        write_reg(REG_AVG_COUNT, '0);
        write_reg(REG_OFS_A_HIGH, 24'h7fffff);
        write_reg(REG_OFS_A_LOW, 24'h7fffff);
        write_reg(REG_OFS_B, 24'h800000);
        end_writes();
        push_conversion(24'h800000, 1);
        push_conversion(24'h7fffff, 1);
        push_conversion(24'hffffff, 1);
        wait_idle();

        // channel B, groups of three spanning a mode change, back-to-back reads
        write_reg(REG_MODE, CFG_W'(MODE_B32));
        write_reg(REG_HALF_PERIOD, 24'd1);
        write_reg(REG_AVG_COUNT, 24'd3);
        end_writes();
        push_conversion(24'h123456, 0);
        push_conversion(24'hfedcba, 0);
        push_conversion(24'h800001, 0);
        push_conversion(24'h000003, 0);
        wait_idle();

        // slowest serial clock through one full high half, count above the maximum
        write_reg(REG_HALF_PERIOD, 24'd255);
        write_reg(REG_AVG_COUNT, 24'h0001ff);
        write_reg(REG_MODE, CFG_W'(MODE_A64));
        end_writes();
        push_tick(1'b1);
        push_tick(1'b0);
        repeat (258) push_tick(1'($urandom_range(0, 1)));
        wait_idle();

        // count lowered below the samples already gathered
        write_reg(REG_HALF_PERIOD, 24'd2);
        write_reg(REG_AVG_COUNT, 24'd1);
        end_writes();
        push_conversion(24'h00ff00, 2);
        wait_idle();

        while (rand_ticks < RANDOM_TICKS || !quiet) begin
            if (rand_ticks >= RANDOM_TICKS / 2)
                quiet = 1'b1;
            write_reg(REG_MODE, CFG_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 1)) begin
                sel = $urandom_range(0, 99);
                val = (sel < 75) ? 1 : (sel < 90) ? $urandom_range(2, 3) :
                      (sel < 97) ? 0 : $urandom_range(4, 12);
                write_reg(REG_HALF_PERIOD, CFG_W'(val));
            end
            if ($urandom_range(0, 2) != 0) begin
                sel = $urandom_range(0, 99);
                val = (sel < 40) ? 1 : (sel < 70) ? $urandom_range(2, 4) :
                      (sel < 80) ? 0 : (sel < 90) ? $urandom_range(5, 12) :
                      $urandom_range(257, 511);
                write_reg(REG_AVG_COUNT, CFG_W'(val));
            end
            for (int k = 0; k < 3; k++)
                if ($urandom_range(0, 1))
                    write_reg(CIDX_W'(REG_OFS_A_HIGH + k), pick_offset());
            end_writes();
            start = ticks_queued;
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 99) < 85)
                    push_conversion(pick_sample(), $urandom_range(0, 3));
                else
                    repeat ($urandom_range(5, 60)) push_tick(1'($urandom_range(0, 1)));
            end
            rand_ticks += ticks_queued - start;
            wait_idle();
        end

        if (expect_q.size() != 0)
            report_mismatch("results left pending", 0, expect_q.size());
        $display("Run: %0d ticks (%0d random) over %0d register settings", ticks_accepted,
                 rand_ticks, settings_used);
        $display("Run: %0d conversions and %0d means checked", samples_seen, means_seen);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
